>>> src/fweg_pkg.sv
package fweg_pkg;

  // Table depth and stream widths
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int VERT_W          = 24;
  localparam int DENS_W          = 24;
  localparam int IDX_IN_W        = 6;
  localparam int WC_W            = 18;
  localparam int ENTRY_W         = 3 * WC_W;
  localparam int SIDE_W          = VERT_W + 1;
  localparam int NRM_W           = 51;
  localparam int NQ_W            = 35;
  localparam int SCORE_W         = 55;
  localparam int OUT_W           = 48;
  localparam int NFIELD          = 10;
  localparam int CFG_W           = 7;
  localparam int IN_DATA_W       = 248;
  localparam int OUT_DATA_W      = NFIELD * OUT_W;

  // Request kinds carried on tuser
  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // Wulff shape selection
  localparam logic [1:0] MODE_TABLE = 2'd0;
  localparam logic [1:0] MODE_HEMI  = 2'd1;
  localparam logic [1:0] MODE_LENS  = 2'd2;

  typedef logic signed [WC_W-1:0] wcomp_t;
  typedef logic signed [NQ_W-1:0] nq_t;

  // Cyclic successor of a vector component index
  function automatic logic [1:0] next3(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Clamp a loaded component to the signed 18-bit range
  function automatic wcomp_t sat_wc(input logic signed [VERT_W-1:0] v);
    wcomp_t r;
    if (v > 24'sd131071) r = 18'sd131071;
    else if (v < -24'sd131072) r = -18'sd131072;
    else r = v[WC_W-1:0];
    return r;
  endfunction

endpackage

>>> src/fweg_table.sv
module fweg_table #(
  parameter int TABLE_DEPTH = fweg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 wr_en,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
  input  fweg_pkg::wcomp_t                                     wr_w [3],
  input  logic                                                 start,
  input  logic [$clog2(TABLE_DEPTH + 1)-1:0]                   count,
  input  fweg_pkg::nq_t                                        nq [3],
  output logic                                                 done,
  output fweg_pkg::wcomp_t                                     best_w [3]
);
  import fweg_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_en;
  logic [CW-1:0]      issue;
  logic               busy;
  logic               v1, v2, v3;
  logic               first;
  logic signed [WC_W+NQ_W-1:0] sp [3];
  logic [ENTRY_W-1:0] sw2, sw3, bw;
  logic signed [SCORE_W-1:0] ssum, best;

  assign rd_en = busy && (issue != count);

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_w[2], wr_w[1], wr_w[0]};
    end
    if (rd_en) begin
      rd_data <= mem[issue[IDX_W-1:0]];
    end
  end

  // Scan control: issue reads, track pipeline, flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= rd_en;
      v2   <= v1;
      v3   <= v2;
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        issue <= '0;
        first <= 1'b1;
      end else if (busy) begin
        if (rd_en) begin
          issue <= issue + 1'b1;
        end
        if (!rd_en && !v1 && !v2 && !v3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      // Keep the first entry with the greatest score
      if (v3 && (first || ssum > best)) begin
        best  <= ssum;
        bw    <= sw3;
        first <= 1'b0;
      end
    end
  end

  // Score pipeline: products, then sum
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sp[k] <= $signed(rd_data[WC_W*k +: WC_W]) * nq[k];
    end
    sw2  <= rd_data;
    ssum <= SCORE_W'(sp[0]) + SCORE_W'(sp[1]) + SCORE_W'(sp[2]);
    sw3  <= sw2;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      best_w[k] = bw[WC_W*k +: WC_W];
    end
  end

endmodule

>>> src/facet_wulff_energy_gradient.sv
// Crystalline facet energy: for a triangle and a density, form the normal,
// choose a Wulff vector W, and return energy = density * (W . N) / 2 and the
// three vertex gradient decrements density * (side x W) / 2, Q32.16
// saturated. A load request writes one table entry. An evaluate request
// works one at a time through a shared sequencer: in table mode the count
// setting, clamped to 1 to TABLE_DEPTH, sets how many entries stream out
// of the table memory at one per cycle. Hemisphere and lens modes run the
// bit-serial normalizing shift, the 32-step square root and three restoring
// divides; the lens outer case runs its divide by three inside the square
// root and drops one divide. In these modes a zero normal skips the square
// root and the divides. The next request is taken while a finished result
// waits on the output.
module facet_wulff_energy_gradient #(
  parameter int TABLE_DEPTH = fweg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z, facet_density,
  // entry_index, zero pad
  input  logic [fweg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // energy, grad0_x, grad0_y, grad0_z, grad1_x .. grad2_z
  output logic [fweg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [fweg_pkg::CFG_W-1:0]        cfg_data
);
  import fweg_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int CNTX  = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CROSS, S_BRANCH, S_SCAN, S_NORM, S_SQ,
    S_SQRT, S_UDIV, S_DOT, S_FIELD, S_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [1:0]       mode;
  logic [CFG_W-1:0] tcount;

  // Request fields
  logic signed [VERT_W-1:0] vin [3][3];
  logic [DENS_W-1:0]        dens_in;
  logic [IDX_IN_W-1:0]      idx_in;
  logic                     s_acc;

  // Working registers
  logic signed [SIDE_W-1:0] side [3][3];
  logic [DENS_W-1:0]        dens;
  logic [2:0]               step;
  logic signed [49:0]       pa, pb;
  logic signed [NRM_W-1:0]  nrm [3];
  nq_t                      nq [3];
  logic [NRM_W-1:0]         m [3];
  logic [2:0]               neg;
  logic [59:0]              sq [3];
  logic                     lens_int;
  logic [63:0]              sr_v, sr_r, sr_b;
  logic [31:0]              nr;
  logic [1:0]               ud_k;
  logic [4:0]               ud_step;
  logic [31:0]              ud_rem;
  logic [17:0]              ud_lo, ud_q;
  wcomp_t                   w [3];
  logic signed [52:0]       ep [3];
  logic signed [39:0]       dval, fv;
  logic signed [64:0]       fprod;
  logic [3:0]               fidx;
  logic [1:0]               fphase, gi, gk;
  logic signed [OUT_W-1:0]  res [NFIELD];
  logic signed [OUT_W-1:0]  out_res [NFIELD];
  logic                     out_valid;

  // Table interface
  logic                     tbl_wr;
  wcomp_t                   tbl_wr_w [3];
  logic                     tbl_start;
  logic [CW-1:0]            tbl_cnt;
  logic                     tbl_done;
  wcomp_t                   tbl_w [3];

  // Combinational helpers
  logic [1:0]               k1, k2, ck, gi1, gk1, gk2;
  logic [NRM_W-1:0]         mx;
  logic [CNTX-1:0]          cnt_x, cnt_c;
  logic [63:0]              sr_sum, sr_rn;
  logic [65:0]              sr_sum3;
  logic                     sr_three;
  logic                     sr_ge;
  logic [46:0]              ud_num;
  logic [32:0]              ud_rem2, ud_sub;
  logic                     ud_ge;
  logic signed [18:0]       ud_w;
  logic [60:0]              sxy;
  logic [61:0]              sz3;
  logic signed [54:0]       esum;
  logic signed [50:0]       gt;
  logic signed [OUT_W-1:0]  fsat;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;

  // Unpack request and result words
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        vin[i][k] = s_axis_tdata[VERT_W*(3*i+k) +: VERT_W];
      end
    end
    dens_in = s_axis_tdata[9*VERT_W +: DENS_W];
    idx_in  = s_axis_tdata[9*VERT_W+DENS_W +: IDX_IN_W];
    for (int i = 0; i < NFIELD; i++) begin
      m_axis_tdata[OUT_W*i +: OUT_W] = out_res[i];
    end
  end

  // Table write port and searched count
  always_comb begin
    tbl_wr = s_acc && (s_axis_tuser == REQ_LOAD) &&
             ({26'b0, idx_in} < 32'(TABLE_DEPTH));
    tbl_wr_w[0] = sat_wc(vin[0][0]);
    tbl_wr_w[1] = sat_wc(vin[0][1]);
    tbl_wr_w[2] = sat_wc(vin[0][2]);
    cnt_x = CNTX'(tcount);
    cnt_c = (cnt_x > CNTX'(TABLE_DEPTH)) ? CNTX'(TABLE_DEPTH) : cnt_x;
    if (cnt_c == '0) cnt_c = CNTX'(1);
    tbl_cnt = cnt_c[CW-1:0];
  end

  fweg_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr),
    .wr_addr (IDX_W'(idx_in)),
    .wr_w    (tbl_wr_w),
    .start   (tbl_start),
    .count   (tbl_cnt),
    .nq      (nq),
    .done    (tbl_done),
    .best_w  (tbl_w)
  );

  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [64:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 65'sd140737488355327) r = {1'b0, {(OUT_W-1){1'b1}}};
    else if (v < -65'sd140737488355328) r = {1'b1, {(OUT_W-1){1'b0}}};
    else r = v[OUT_W-1:0];
    return r;
  endfunction

  // Datapath helpers for the sequencer
  always_comb begin
    k1  = next3(step[1:0]);
    k2  = next3(k1);
    ck  = step[1:0] - 2'd1;
    gi1 = next3(gi);
    gk1 = next3(gk);
    gk2 = next3(gk1);

    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];

    // Lens outer case: root of floor(4 sxy / 3) is the largest r with 3 r^2 <= 4 sxy
    sr_three = (mode == MODE_LENS) && !lens_int;
    sr_sum   = sr_r + sr_b;
    sr_sum3  = {2'b0, sr_sum} + {1'b0, sr_sum, 1'b0};
    sr_ge    = sr_three ? ({2'b0, sr_v} >= sr_sum3) : (sr_v >= sr_sum);
    sr_rn    = sr_ge ? ((sr_r >> 1) + sr_b) : (sr_r >> 1);

    ud_num  = {1'b0, m[ud_k][29:0], 16'b0} + {16'b0, nr[31:1]};
    ud_rem2 = {ud_rem, ud_lo[17]};
    ud_sub  = ud_rem2 - {1'b0, nr};
    ud_ge   = (ud_rem2 >= {1'b0, nr});
    ud_w    = neg[ud_k] ? -$signed({1'b0, ud_q}) : $signed({1'b0, ud_q});
    if (lens_int && ud_k == 2'd2) ud_w = ud_w - 19'sd32768;

    sxy = {1'b0, sq[0]} + {1'b0, sq[1]};
    sz3 = {2'b0, sq[2]} + {1'b0, sq[2], 1'b0};

    esum = 55'(ep[0]) + 55'(ep[1]) + 55'(ep[2]);
    gt   = 51'(pa) - 51'(pb);
    fsat = sat48((fprod + 65'sd65536) >>> 17);
  end

  // Sequencer: state, configuration and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_TABLE;
      tcount    <= '0;
      out_valid <= 1'b0;
      tbl_start <= 1'b0;
    end else begin
      tbl_start <= 1'b0;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;

      // Take register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:  mode   <= cfg_data[1:0];
          CFG_COUNT: tcount <= cfg_data;
          default:   mode   <= mode;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser == REQ_LOAD) begin
              for (int i = 0; i < NFIELD; i++) res[i] <= '0;
              state <= S_DONE;
            end else begin
              for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                  side[i][k] <= vin[next3(2'(i))][k] - vin[i][k];
                end
              end
              dens  <= dens_in;
              step  <= '0;
              state <= S_CROSS;
            end
          end
        end

        // Normal = side0 x side1, one component per cycle
        S_CROSS: begin
          if (step != 3'd3) begin
            pa <= side[0][k1] * side[1][k2];
            pb <= side[0][k2] * side[1][k1];
          end
          if (step != 3'd0) nrm[ck] <= 51'(pa) - 51'(pb);
          step <= step + 3'd1;
          if (step == 3'd3) state <= S_BRANCH;
        end

        S_BRANCH: begin
          for (int k = 0; k < 3; k++) begin
            nq[k] <= NQ_W'((nrm[k] + 51'sd32768) >>> 16);
          end
          for (int k = 0; k < 3; k++) begin
            neg[k] <= nrm[k][NRM_W-1];
            m[k]   <= nrm[k][NRM_W-1] ? NRM_W'(-nrm[k]) : nrm[k];
          end
          lens_int <= 1'b0;
          case (mode)
            MODE_HEMI: begin
              // Upper hemisphere drops a downward z
              if (nrm[2][NRM_W-1]) begin
                neg[2] <= 1'b0;
                m[2]   <= '0;
              end
              state <= S_NORM;
            end
            MODE_LENS: state <= S_NORM;
            default: begin
              tbl_start <= 1'b1;
              state     <= S_SCAN;
            end
          endcase
        end

        S_SCAN: begin
          if (tbl_done) begin
            for (int k = 0; k < 3; k++) w[k] <= tbl_w[k];
            step  <= '0;
            state <= S_DOT;
          end
        end

        // Shift one bit per cycle until the largest lies in [2^29, 2^30)
        S_NORM: begin
          if (mx == '0) begin
            for (int k = 0; k < 3; k++) w[k] <= '0;
            step  <= '0;
            state <= S_DOT;
          end else if (mx[NRM_W-1:30] != '0) begin
            for (int k = 0; k < 3; k++) m[k] <= m[k] >> 1;
          end else if (!mx[29]) begin
            for (int k = 0; k < 3; k++) m[k] <= m[k] << 1;
          end else begin
            step  <= '0;
            state <= S_SQ;
          end
        end

        // Square each magnitude, then choose the radicand
        S_SQ: begin
          if (step != 3'd3) begin
            sq[step[1:0]] <= m[step[1:0]][29:0] * m[step[1:0]][29:0];
            step <= step + 3'd1;
          end else if (mode == MODE_LENS && !({1'b0, sxy} < sz3)) begin
            sr_v  <= {1'b0, sxy, 2'b0};
            sr_r  <= '0;
            sr_b  <= 64'h4000_0000_0000_0000;
            w[2]  <= '0;
            state <= S_SQRT;
          end else begin
            lens_int <= (mode == MODE_LENS);
            sr_v  <= {3'b0, sxy} + {4'b0, sq[2]};
            sr_r  <= '0;
            sr_b  <= 64'h4000_0000_0000_0000;
            state <= S_SQRT;
          end
        end

        // Integer square root, one result bit per cycle
        S_SQRT: begin
          if (sr_ge) sr_v <= sr_v - (sr_three ? sr_sum3[63:0] : sr_sum);
          sr_r <= sr_rn;
          sr_b <= sr_b >> 2;
          if (sr_b == 64'd1) begin
            nr      <= sr_rn[31:0];
            ud_k    <= '0;
            ud_step <= '0;
            state   <= S_UDIV;
          end
        end

        // Rounded unit component, restoring divide by the norm
        S_UDIV: begin
          if (ud_step == 5'd0) begin
            ud_rem  <= {3'b0, ud_num[46:18]};
            ud_lo   <= ud_num[17:0];
            ud_q    <= '0;
            ud_step <= ud_step + 5'd1;
          end else if (ud_step != 5'd19) begin
            ud_rem  <= ud_ge ? ud_sub[31:0] : ud_rem2[31:0];
            ud_lo   <= {ud_lo[16:0], 1'b0};
            ud_q    <= {ud_q[16:0], ud_ge};
            ud_step <= ud_step + 5'd1;
          end else begin
            w[ud_k]  <= ud_w[WC_W-1:0];
            ud_step  <= '0;
            ud_k     <= ud_k + 2'd1;
            if (ud_k == 2'd2 || (mode == MODE_LENS && !lens_int && ud_k == 2'd1)) begin
              step  <= '0;
              state <= S_DOT;
            end
          end
        end

        // W . NQ, rounded to Q.16
        S_DOT: begin
          if (step == 3'd0) begin
            for (int k = 0; k < 3; k++) ep[k] <= w[k] * nq[k];
            step <= 3'd1;
          end else begin
            dval   <= 40'((esum + 55'sd32768) >>> 16);
            fidx   <= '0;
            fphase <= '0;
            gi     <= '0;
            gk     <= '0;
            state  <= S_FIELD;
          end
        end

        // One output field at a time: cross term, scale by density, round
        S_FIELD: begin
          case (fphase)
            2'd0: begin
              if (fidx == 4'd0) begin
                fv     <= dval;
                fphase <= 2'd2;
              end else begin
                pa     <= side[gi1][gk1] * w[gk2];
                pb     <= side[gi1][gk2] * w[gk1];
                fphase <= 2'd1;
              end
            end
            2'd1: begin
              fv     <= 40'((gt + 51'sd32768) >>> 16);
              fphase <= 2'd2;
            end
            2'd2: begin
              fprod  <= fv * $signed({1'b0, dens});
              fphase <= 2'd3;
            end
            default: begin
              res[fidx] <= fsat;
              fphase    <= 2'd0;
              if (fidx != 4'd0) begin
                if (gk == 2'd2) begin
                  gk <= '0;
                  gi <= gi + 2'd1;
                end else begin
                  gk <= gk + 2'd1;
                end
              end
              if (fidx == 4'(NFIELD - 1)) state <= S_DONE;
              else fidx <= fidx + 4'd1;
            end
          endcase
        end

        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            for (int i = 0; i < NFIELD; i++) out_res[i] <= res[i];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Table completion only arrives while the sequencer waits for it
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    tbl_done |-> state == S_SCAN)
    else $error("table scan finished outside scan wait");

  // A load request goes straight to the result stage
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tuser == REQ_LOAD) |=> state == S_DONE)
    else $error("load request did not produce a result");

  // Scaled magnitudes are normalized before squaring
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ && step == 3'd0) |-> (mx[NRM_W-1:30] == '0 && mx[29]))
    else $error("magnitudes not normalized");

  // The divisor is never zero
  a_nr_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_UDIV |-> nr != '0)
    else $error("zero norm in unit divide");
`endif

endmodule

>>> dv/facet_wulff_energy_gradient_tb.sv
`timescale 1ns / 1ps

module facet_wulff_energy_gradient_tb;
  import fweg_pkg::*;

  localparam int  TAB_N       = 64;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  PHASE_ITEMS = 147;
  localparam int  NPHASE      = 10;
  localparam longint SAT_HI   = 64'sd140737488355327;
  localparam longint SAT_LO   = -64'sd140737488355328;

  typedef logic [8:0][VERT_W-1:0] tri_t;

  typedef struct {
    bit                 is_cfg;
    logic               cfg_sel;
    logic [CFG_W-1:0]   cfg_val;
    logic               kind;
    tri_t               v;
    logic [DENS_W-1:0]  dens;
    logic [5:0]         idx;
    bit                 zero_res;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // Shadow of the block's state
  longint                 wulff_tab [TAB_N][3];
  logic [1:0]             cur_mode;
  logic [6:0]             cur_count;

  logic [OUT_DATA_W-1:0]  energy_grad_q [$];
  stim_row_t              rows [$];
  int                     mismatch_cnt;
  int                     cycle_cnt;
  bit                     quiet;
  bit                     hold_req;

  facet_wulff_energy_gradient u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Fixed-point helpers
  // ---------------------------------------------------------------------
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [OUT_W-1:0] sat48(longint v);
    longint c;
    c = v;
    if (c > SAT_HI) c = SAT_HI;
    if (c < SAT_LO) c = SAT_LO;
    return c[OUT_W-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b, v;
    r = 0;
    v = x;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(longint unsigned m, longint unsigned nr, bit neg);
    longint unsigned q;
    if (nr == 0) return 0;
    q = (m * 65536 + nr / 2) / nr;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint dot3(longint a[3], longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Unit normal for hemisphere and lens shapes; zero normal gives zero W
  function automatic void shape_vec(input longint n[3], input bit lens,
                                    output longint w[3]);
    longint unsigned m[3], mx, sxy, sz, nr;
    m[0] = 0; m[1] = 0; m[2] = 0;
    mx = 0;
    w[0] = 0; w[1] = 0; w[2] = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = n[i] < 0 ? longint'(-n[i]) : n[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    sxy = m[0] * m[0] + m[1] * m[1];
    sz  = m[2] * m[2];
    if (!lens) begin
      nr = int_sqrt(sxy + sz);
      for (int i = 0; i < 3; i++) w[i] = unit_comp(m[i], nr, n[i] < 0);
    end else if (sxy < 3 * sz) begin
      // interior of the lens: shift the unit normal down by one half
      nr = int_sqrt(sxy + sz);
      for (int i = 0; i < 3; i++) w[i] = unit_comp(m[i], nr, n[i] < 0);
      w[2] = w[2] - 32768;
    end else begin
      nr = int_sqrt(sxy * 4 / 3);
      w[0] = unit_comp(m[0], nr, n[0] < 0);
      w[1] = unit_comp(m[1], nr, n[1] < 0);
    end
  endfunction

  // Energy and gradient decrements of one request; a load updates the table
  function automatic logic [OUT_DATA_W-1:0] facet_energy(logic kind, tri_t v,
                                                         logic [DENS_W-1:0] dens,
                                                         logic [5:0] idx);
    logic [OUT_DATA_W-1:0] res;
    longint vt[3][3], side[3][3], nrm[3], nq[3], w[3], hv[3], t[3], ent[3];
    longint c, d, dn, bestd, s;
    int cnt, best;
    res = '0;
    dn  = longint'({40'd0, dens});
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        vt[i][k] = longint'($signed(v[3 * i + k]));
    if (kind == REQ_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        c = vt[0][k];
        if (c > 131071) c = 131071;
        if (c < -131072) c = -131072;
        wulff_tab[idx][k] = c;
      end
      return res;
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        side[i][k] = vt[(i + 1) % 3][k] - vt[i][k];
    cross3(side[0], side[1], nrm);
    for (int k = 0; k < 3; k++) nq[k] = rnd_shift(nrm[k], 16);
    if (cur_mode == MODE_HEMI) begin
      hv = nrm;
      if (hv[2] < 0) hv[2] = 0;
      shape_vec(hv, 1'b0, w);
    end else if (cur_mode == MODE_LENS) begin
      shape_vec(nrm, 1'b1, w);
    end else begin
      // table search: greatest score wins, first on ties
      cnt  = cur_count > TAB_N ? TAB_N : int'(cur_count);
      best = 0;
      ent  = wulff_tab[0];
      bestd = dot3(ent, nq);
      for (int j = 1; j < cnt; j++) begin
        ent = wulff_tab[j];
        s = dot3(ent, nq);
        if (s > bestd) begin
          bestd = s;
          best  = j;
        end
      end
      w = wulff_tab[best];
    end
    d = rnd_shift(dot3(w, nq), 16);
    res[0 +: OUT_W] = sat48(rnd_shift(d * dn, 17));
    for (int i = 0; i < 3; i++) begin
      cross3(side[(i + 1) % 3], w, t);
      for (int k = 0; k < 3; k++)
        res[OUT_W * (1 + 3 * i + k) +: OUT_W] = sat48(rnd_shift(rnd_shift(t[k], 16) * dn, 17));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic stim_row_t mk_cfg(logic sel, int val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = CFG_W'(val);
    return r;
  endfunction

  function automatic stim_row_t mk_req(logic kind, int x0, int y0, int z0, int x1, int y1,
                                       int z1, int x2, int y2, int z2, int dens, int idx,
                                       bit zero_res);
    stim_row_t r;
    r = '{default: '0};
    r.kind = kind;
    r.v[0] = 24'(x0); r.v[1] = 24'(y0); r.v[2] = 24'(z0);
    r.v[3] = 24'(x1); r.v[4] = 24'(y1); r.v[5] = 24'(z1);
    r.v[6] = 24'(x2); r.v[7] = 24'(y2); r.v[8] = 24'(z2);
    r.dens = 24'(dens);
    r.idx  = 6'(idx);
    r.zero_res = zero_res;
    return r;
  endfunction

  function automatic logic [VERT_W-1:0] rand_coord(int sel);
    logic [VERT_W-1:0] r;
    case (sel)
      0: r = 24'($urandom);
      1: r = 24'($urandom_range(0, 131071)) - 24'd65536;
      2: r = 24'($urandom_range(0, 1023)) - 24'd512;
      default: begin
        case ($urandom_range(0, 3))
          0: r = 24'h7FFFFF;
          1: r = 24'h800000;
          2: r = 24'h000000;
          default: r = 24'hFFFFFF;
        endcase
      end
    endcase
    return r;
  endfunction

  // Wulff component for a load: mostly in range, sometimes beyond it
  function automatic logic [VERT_W-1:0] rand_wcomp();
    if ($urandom_range(0, 9) == 0) return rand_coord($urandom_range(0, 3));
    return 24'($urandom_range(0, 262143)) - 24'd131072;
  endfunction

  // Offer one request; tvalid stays high on return unless a gap follows
  task automatic send_req(logic kind, tri_t v, logic [DENS_W-1:0] dens, logic [5:0] idx,
                          bit zero_res);
    logic [OUT_DATA_W-1:0] want;
    if (!quiet && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tdata  = {2'b00, idx, dens, v};
    s_axis_tuser  = kind;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    want = facet_energy(kind, v, dens, idx);
    if (zero_res) want = '0;
    energy_grad_q.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (energy_grad_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic sel, logic [CFG_W-1:0] val);
    drain();
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == CFG_MODE) cur_mode = val[1:0];
    else cur_count = val;
  endtask

  task automatic send_random();
    tri_t v;
    int sel;
    logic kind;
    kind = ($urandom_range(0, 99) < 12) ? REQ_LOAD : REQ_EVAL;
    sel  = $urandom_range(0, 9) < 4 ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < 9; i++) v[i] = rand_coord(sel);
    if (kind == REQ_LOAD) begin
      for (int k = 0; k < 3; k++) v[k] = rand_wcomp();
    end else if ($urandom_range(0, 19) == 0) begin
      // degenerate triangle: two vertices coincide
      for (int k = 0; k < 3; k++) v[6 + k] = v[k];
    end
    send_req(kind, v, 24'($urandom), 6'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (1500) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready = quiet || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (energy_grad_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = energy_grad_q.pop_front();
        for (int f = 0; f < NFIELD; f++) begin
          if (m_axis_tdata[OUT_W * f +: OUT_W] !== want[OUT_W * f +: OUT_W]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("field %0d mismatch: expected %h actual %h", f,
                       want[OUT_W * f +: OUT_W], m_axis_tdata[OUT_W * f +: OUT_W]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    tri_t v;
    stim_row_t r;
    int counts[NPHASE];
    logic [1:0] modes[NPHASE];

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_EVAL;
    cfg_we = 1'b0; cfg_index = CFG_MODE; cfg_data = '0;
    mismatch_cnt = 0; cycle_cnt = 0;
    quiet = 1'b0; hold_req = 1'b0;
    cur_mode = MODE_TABLE; cur_count = '0;
    for (int e = 0; e < TAB_N; e++)
      for (int k = 0; k < 3; k++) wulff_tab[e][k] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows: extremes, every mode and the named corner cases
    rows.push_back(mk_req(REQ_LOAD, 8388607, -8388608, 0, 5, 6, 7, 8, 9, 10, 1, 0, 1));
    rows.push_back(mk_req(REQ_LOAD, -131072, 131071, 77, 0, 0, 0, 0, 0, 0, 0, 63, 1));
    rows.push_back(mk_req(REQ_EVAL, -8388608, -8388608, -8388608, 8388607, -8388608,
                          8388607, 8388607, 8388607, -8388608, 16777215, 0, 0));
    rows.push_back(mk_req(REQ_EVAL, -8388608, -8388608, -8388608, 8388607, -8388608,
                          8388607, 8388607, 8388607, -8388608, 0, 0, 1));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 0, 0));
    rows.push_back(mk_cfg(CFG_COUNT, 1));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 0, 65536, 0, 65536, 0, 0, 65536, 0, 0));
    rows.push_back(mk_cfg(CFG_MODE, MODE_HEMI));
    rows.push_back(mk_req(REQ_EVAL, 100, 200, 300, 100, 200, 300, 100, 200, 300,
                          16777215, 0, 1));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 65536, 65536, 65536, 131072, 131072, 131072,
                          16777215, 0, 1));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 0, 0));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 0, 65536, 0, 65536, 0, 0, 65536, 0, 0));
    rows.push_back(mk_req(REQ_EVAL, -8388608, -8388608, -8388608, 8388607, -8388608,
                          8388607, 8388607, 8388607, -8388608, 16777215, 0, 0));
    rows.push_back(mk_cfg(CFG_MODE, MODE_LENS));
    rows.push_back(mk_req(REQ_EVAL, 5, 5, 5, 5, 5, 5, 5, 5, 5, 65536, 0, 1));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 0, 0));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 0, 65536, 0, 0, 0, 65536, 65536, 0, 0));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 0, 65536, 0, 65536, 0, 0, 65536, 0, 0));
    rows.push_back(mk_req(REQ_EVAL, -8388608, -8388608, -8388608, 8388607, -8388608,
                          8388607, 8388607, 8388607, -8388608, 16777215, 0, 0));
    rows.push_back(mk_cfg(CFG_MODE, 3));
    rows.push_back(mk_req(REQ_EVAL, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 0, 0));

    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) write_reg(r.cfg_sel, r.cfg_val);
      else send_req(r.kind, r.v, r.dens, r.idx, r.zero_res);
    end

    // Load every table entry so that any count reads written entries only
    for (int e = 0; e < TAB_N; e++) begin
      for (int i = 0; i < 9; i++) v[i] = rand_coord($urandom_range(0, 3));
      for (int k = 0; k < 3; k++) v[k] = rand_wcomp();
      send_req(REQ_LOAD, v, 24'($urandom), 6'(e), 1'b0);
    end

    // Random phases over a spread of settings
    modes  = '{MODE_TABLE, MODE_HEMI, MODE_LENS, 2'd3, MODE_TABLE, MODE_HEMI, MODE_LENS,
               MODE_TABLE, MODE_LENS, MODE_TABLE};
    counts = '{64, 127, 5, 65, 0, 1, 63, 2, 40, 0};
    counts[9] = $urandom_range(2, 64);
    for (int p = 0; p < NPHASE; p++) begin
      write_reg(CFG_MODE, CFG_W'(modes[p]));
      write_reg(CFG_COUNT, CFG_W'(counts[p]));
      quiet = (p == 0);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end
    quiet = 1'b0;

    drain();
    repeat (300) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
